>>> src/query_statement_guard_unit_defines.svh
`ifndef QUERY_STATEMENT_GUARD_UNIT_DEFINES_SVH
`define QUERY_STATEMENT_GUARD_UNIT_DEFINES_SVH

// same-cycle implication, checked on clk, idle during reset
`define QSG_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qsg assertion failed");

// next-cycle implication, checked on clk, idle during reset
`define QSG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qsg assertion failed");

`endif

>>> src/qsg_pkg.sv
package qsg_pkg;

  localparam int unsigned KW_MAX_CHARS = 8;
  localparam int unsigned TOK_IDX_W = $clog2(KW_MAX_CHARS);
  localparam int unsigned TOK_LEN_W = $clog2(KW_MAX_CHARS + 2);
  localparam int unsigned KW_COUNT = 5;
  localparam int unsigned KW_TEXT_LEN = 8;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DASH = 8'h2D;
  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_NL = 8'h0A;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_SEMI = 8'h3B;

  typedef logic [7:0] tok_chars_t [KW_MAX_CHARS];

  typedef enum logic [2:0] {
    KW_SELECT   = 3'd0,
    KW_EVALUATE = 3'd1,
    KW_WITH     = 3'd2,
    KW_DEFINE   = 3'd3,
    KW_VAR      = 3'd4,
    KW_NONE     = 3'd5
  } kw_idx_t;

  typedef enum logic [1:0] {
    VD_ACCEPT      = 2'd0,
    VD_BAD_KEYWORD = 2'd1,
    VD_BATCH       = 2'd2
  } verdict_t;

  typedef struct packed {
    verdict_t verdict;
    kw_idx_t  keyword;
  } result_t;

  localparam logic [7:0] KW_TEXT [KW_COUNT][KW_TEXT_LEN] = '{
    '{"S", "E", "L", "E", "C", "T", 8'h00, 8'h00},
    '{"E", "V", "A", "L", "U", "A", "T", "E"},
    '{"W", "I", "T", "H", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"D", "E", "F", "I", "N", "E", 8'h00, 8'h00},
    '{"V", "A", "R", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };
  localparam int unsigned KW_LEN [KW_COUNT] = '{6, 8, 4, 6, 3};

  function automatic kw_idx_t match_keyword(input tok_chars_t chars,
                                            input logic [TOK_LEN_W-1:0] len);
    kw_idx_t idx;
    logic    hit;
    idx = KW_NONE;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      hit = (len == TOK_LEN_W'(KW_LEN[k]));
      for (int n = 0; n < KW_TEXT_LEN; n++) begin
        if (n < KW_LEN[k] && chars[n] != KW_TEXT[k][n]) hit = 1'b0;
      end
      if (hit) idx = kw_idx_t'(k);
    end
    return idx;
  endfunction

endpackage

>>> src/qsg_lexer.sv
module qsg_lexer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        data_byte,
  input  logic              last,
  output qsg_pkg::result_t  result
);
  import qsg_pkg::*;

  typedef enum logic [2:0] {
    PH_TRIVIA = 3'b001,
    PH_TOKEN  = 3'b010,
    PH_DONE   = 3'b100
  } phase_t;

  typedef enum logic [7:0] {
    MD_NORMAL      = 8'b0000_0001,
    MD_LINE        = 8'b0000_0010,
    MD_BLOCK       = 8'b0000_0100,
    MD_BLOCK_STAR  = 8'b0000_1000,
    MD_QUOTE       = 8'b0001_0000,
    MD_QUOTE_END   = 8'b0010_0000,
    MD_BRACKET     = 8'b0100_0000,
    MD_BRACKET_END = 8'b1000_0000
  } mode_t;

  typedef enum logic [2:0] {
    PO_NONE  = 3'b001,
    PO_SLASH = 3'b010,
    PO_DASH  = 3'b100
  } opener_t;

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  phase_t                phase_r, phase_nxt;
  mode_t                 mode_r, mode_nxt;
  opener_t               po_r, po_nxt;
  logic                  dquote_r, dquote_nxt;
  logic                  sep_r, sep_nxt;
  logic                  viol_r, viol_nxt;
  tok_chars_t            chars_r, chars_nxt;
  logic [TOK_LEN_W-1:0]  len_r, len_nxt;

  logic                  add_char, norm_path, do_norm, do_drop, opener;
  logic [7:0]            q_char, up_char;
  phase_t                phase_fin;
  logic                  viol_fin;
  kw_idx_t               kw;

  always_comb begin
    phase_nxt  = phase_r;
    mode_nxt   = mode_r;
    po_nxt     = po_r;
    dquote_nxt = dquote_r;
    sep_nxt    = sep_r;
    viol_nxt   = viol_r;
    chars_nxt  = chars_r;
    len_nxt    = len_r;
    add_char   = 1'b0;
    norm_path  = 1'b0;
    do_norm    = 1'b0;
    do_drop    = 1'b0;
    opener     = (data_byte == CH_SLASH) || (data_byte == CH_DASH);
    q_char     = dquote_r ? CH_DQUOTE : CH_SQUOTE;
    up_char    = (data_byte >= "a" && data_byte <= "z") ? (data_byte & 8'hDF) : data_byte;

    if (phase_r == PH_TOKEN) begin
      if (is_word(data_byte)) add_char = 1'b1;
      else phase_nxt = PH_DONE;
    end

    case (mode_r)
      MD_NORMAL: norm_path = 1'b1;
      MD_LINE: begin
        if (data_byte == CH_NL) mode_nxt = MD_NORMAL;
      end
      MD_BLOCK: begin
        if (data_byte == CH_STAR) mode_nxt = MD_BLOCK_STAR;
      end
      MD_BLOCK_STAR: begin
        if (data_byte == CH_SLASH) mode_nxt = MD_NORMAL;
        else if (data_byte != CH_STAR) mode_nxt = MD_BLOCK;
      end
      MD_QUOTE: begin
        if (data_byte == q_char) mode_nxt = MD_QUOTE_END;
      end
      MD_QUOTE_END: begin
        if (data_byte == q_char) begin
          mode_nxt = MD_QUOTE;
        end else begin
          mode_nxt = MD_NORMAL;
          do_norm  = 1'b1;
        end
      end
      MD_BRACKET: begin
        if (data_byte == CH_RBRACK) mode_nxt = MD_BRACKET_END;
      end
      MD_BRACKET_END: begin
        if (data_byte == CH_RBRACK) begin
          mode_nxt = MD_BRACKET;
        end else begin
          mode_nxt = MD_NORMAL;
          do_norm  = 1'b1;
        end
      end
      default: norm_path = 1'b1;
    endcase

    if (norm_path) begin
      mode_nxt = MD_NORMAL;
      if (po_r == PO_SLASH && data_byte == CH_SLASH) begin
        po_nxt   = PO_NONE;
        mode_nxt = MD_LINE;
      end else if (po_r == PO_SLASH && data_byte == CH_STAR) begin
        po_nxt   = PO_NONE;
        mode_nxt = MD_BLOCK;
      end else if (po_r == PO_DASH && data_byte == CH_DASH) begin
        po_nxt   = PO_NONE;
        mode_nxt = MD_LINE;
      end else begin
        do_drop = (po_r != PO_NONE);
        do_norm = 1'b1;
      end
    end

    // a pending opener that starts no comment is plain text
    if (do_drop) begin
      po_nxt = PO_NONE;
      if (sep_nxt) viol_nxt = 1'b1;
      if (phase_nxt == PH_TRIVIA) phase_nxt = PH_DONE;
    end

    if (do_norm) begin
      if (phase_nxt == PH_TRIVIA && !is_space(data_byte) && !opener) begin
        if (is_word(data_byte)) begin
          phase_nxt = PH_TOKEN;
          add_char  = 1'b1;
        end else begin
          phase_nxt = PH_DONE;
        end
      end
      if (opener) begin
        po_nxt = (data_byte == CH_SLASH) ? PO_SLASH : PO_DASH;
      end else if (sep_nxt) begin
        if (!is_space(data_byte)) viol_nxt = 1'b1;
      end else if (data_byte == CH_SQUOTE || data_byte == CH_DQUOTE) begin
        mode_nxt   = MD_QUOTE;
        dquote_nxt = (data_byte == CH_DQUOTE);
      end else if (data_byte == CH_LBRACK) begin
        mode_nxt = MD_BRACKET;
      end else if (data_byte == CH_SEMI) begin
        sep_nxt = 1'b1;
      end
    end

    if (add_char) begin
      if (len_r < TOK_LEN_W'(KW_MAX_CHARS)) begin
        chars_nxt[len_r[TOK_IDX_W-1:0]] = up_char;
        len_nxt = len_r + 1'b1;
      end else begin
        len_nxt = TOK_LEN_W'(KW_MAX_CHARS + 1);
      end
    end

    // end of statement: a trailing opener is plain text too
    phase_fin = phase_nxt;
    viol_fin  = viol_nxt;
    if (po_nxt != PO_NONE) begin
      if (sep_nxt) viol_fin = 1'b1;
      if (phase_fin == PH_TRIVIA) phase_fin = PH_DONE;
    end

    kw = (phase_fin == PH_TRIVIA) ? KW_NONE : match_keyword(chars_nxt, len_nxt);
    result.keyword = kw;
    if (kw == KW_NONE) result.verdict = VD_BAD_KEYWORD;
    else if (viol_fin) result.verdict = VD_BATCH;
    else result.verdict = VD_ACCEPT;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_TRIVIA;
      mode_r   <= MD_NORMAL;
      po_r     <= PO_NONE;
      dquote_r <= 1'b0;
      sep_r    <= 1'b0;
      viol_r   <= 1'b0;
      len_r    <= '0;
    end else if (step) begin
      if (last) begin
        phase_r  <= PH_TRIVIA;
        mode_r   <= MD_NORMAL;
        po_r     <= PO_NONE;
        dquote_r <= 1'b0;
        sep_r    <= 1'b0;
        viol_r   <= 1'b0;
        len_r    <= '0;
      end else begin
        phase_r  <= phase_nxt;
        mode_r   <= mode_nxt;
        po_r     <= po_nxt;
        dquote_r <= dquote_nxt;
        sep_r    <= sep_nxt;
        viol_r   <= viol_nxt;
        len_r    <= len_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) chars_r <= chars_nxt;
  end

endmodule

>>> src/query_statement_guard_unit.sv
// query statement guard: checks the leading keyword and batch separators of a statement
// input channel: in_data_byte, in_last with in_valid/in_ready, one byte per transfer;
//   in_last marks the final byte of a statement, every statement has at least one byte
// output channel: out_verdict, out_keyword_index with out_valid/out_ready, exactly one
//   transfer per statement, made for its last byte, none for the other bytes
// verdict: 0 accepted, 1 leading token is not an allowed keyword, 2 ';' followed by text
// keyword_index: 0 SELECT, 1 EVALUATE, 2 WITH, 3 DEFINE, 4 VAR, 5 no match
// throughput: one byte per cycle while no last byte waits on the output register; the
//   lexer state steps from the input register, so consecutive bytes flow without gaps
// result path: the last byte's result is loaded into the output register as that byte
//   leaves the input register, provided the output register is free by then
// stall: while a result waits on out_ready, non-last bytes still flow through the lexer;
//   a last byte holds in the input register, and in_ready drops, until the output frees
// reset: synchronous, active low on rst_n; it empties the input and output registers and
//   returns the lexer to leading-trivia state, ready for a new statement next cycle
module query_statement_guard_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_verdict,
  output logic [2:0] out_keyword_index
);
  import qsg_pkg::*;

  `include "query_statement_guard_unit_defines.svh"

  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       out_valid_r, out_valid_nxt;
  result_t    out_res_r;
  result_t    lex_res;
  logic       advance;

  assign advance  = s1_valid_r && (!s1_last_r || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  qsg_lexer u_lexer (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .data_byte (s1_byte_r),
    .last      (s1_last_r),
    .result    (lex_res)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_valid && in_ready) s1_valid_nxt = 1'b1;
    else if (advance) s1_valid_nxt = 1'b0;

    out_valid_nxt = out_valid_r;
    if (advance && s1_last_r) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_data_byte;
      s1_last_r <= in_last;
    end
    if (advance && s1_last_r) out_res_r <= lex_res;
  end

  assign out_valid         = out_valid_r;
  assign out_verdict       = out_res_r.verdict;
  assign out_keyword_index = out_res_r.keyword;

  // a last byte must not overwrite a result still waiting downstream
  `QSG_ASSERT_NOW(a_last_holds_on_stall,
                  s1_valid_r && s1_last_r && out_valid_r && !out_ready, !in_ready)
  // a last byte leaving the input register always produces a result
  `QSG_ASSERT_NEXT(a_last_gives_result, advance && s1_last_r, out_valid_r)
  // no keyword match always reports the bad-keyword verdict
  `QSG_ASSERT_NOW(a_none_is_bad_keyword,
                  out_valid_r && out_res_r.keyword == KW_NONE,
                  out_res_r.verdict == VD_BAD_KEYWORD)
  // a bad-keyword verdict only comes with no match
  `QSG_ASSERT_NOW(a_bad_keyword_is_none,
                  out_valid_r && out_res_r.verdict == VD_BAD_KEYWORD,
                  out_res_r.keyword == KW_NONE)

endmodule
